// ----- hdl/brle_pkg.sv -----
// Package for the byte run-length encoder: command record passed from the
// classifier to the record emitter, emitter state type and fixed widths.
// No dependencies.
package brle_pkg;

    localparam int unsigned RUN_W   = 7;                // run length, 0..127
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LANES   = 8;                // bytes per result word
    localparam int unsigned ROW_W   = 4;                // literal store row index
    localparam int unsigned ROWS    = 16;
    localparam int unsigned WORD_W  = LANES * BYTE_W;
    localparam int unsigned TAIL_W  = 32;               // up to two repeat records
    localparam int unsigned TLEN_W  = 3;
    localparam int unsigned POS_W   = 8;                // byte position in one item

    // a repeat shorter than this that meets a new byte turns into a literal
    localparam logic [RUN_W-1:0]  SHORT_REPEAT = 7'd3;
    // bytes in one repeat record: header and value
    localparam logic [TLEN_W-1:0] REPEAT_BYTES = 3'd2;

    typedef struct packed {
        logic                    wr_pair;   // write two bytes after the literal is read
        logic [RUN_W-1:0]        wr_idx;
        logic [BYTE_W-1:0]       wr_lo;
        logic [BYTE_W-1:0]       wr_hi;
        logic                    lit_en;    // literal record leads the item's bytes
        logic [RUN_W-1:0]        lit_n;
        logic [TLEN_W-1:0]       tail_len;  // repeat record bytes after the literal
        logic [TAIL_W-1:0]       tail;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } t_back_state;

endpackage

// ----- hdl/brle_front.sv -----
// Classifier of the byte run-length encoder: tracks the open run and turns
// each transaction into one command for the emitter.
// Depends on brle_pkg.
module brle_front #(
    parameter int unsigned MAX_RUN = 127
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [brle_pkg::BYTE_W-1:0]    i_value,
    input  logic                           i_end_of_line,
    input  logic                           i_full,
    output logic                           o_push,
    output brle_pkg::t_cmd                 o_cmd
);

    localparam logic [brle_pkg::RUN_W-1:0] RUN_LIMIT = brle_pkg::RUN_W'(MAX_RUN);

    logic [brle_pkg::BYTE_W-1:0]  r_prev,      n_prev;
    logic [brle_pkg::RUN_W-1:0]   r_run_count, n_run_count;
    logic                         r_repeat,    n_repeat;

    logic                         accept;
    logic                         same;
    logic                         close;
    logic [brle_pkg::RUN_W-1:0]   mid_count;
    logic                         mid_repeat;
    logic [15:0]                  close_rec;
    brle_pkg::t_cmd               cmd;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept;
    assign o_cmd   = cmd;

    always_comb begin
        cmd          = '0;
        cmd.wr_idx   = r_run_count;
        cmd.wr_lo    = i_value;
        cmd.wr_hi    = i_value;
        same         = (i_value == r_prev);
        mid_count    = r_run_count + 7'd1;
        mid_repeat   = r_repeat;
        close_rec    = '0;

        if (r_run_count == '0) begin
            mid_count  = 7'd1;
            mid_repeat = 1'b1;
            cmd.wr_idx = '0;
        end else if (r_repeat) begin
            if (!same) begin
                if (r_run_count < brle_pkg::SHORT_REPEAT) begin
                    mid_repeat = 1'b0;
                end else begin
                    // repeat broken: emit it, the new byte opens a run
                    cmd.tail[15:0] = {r_prev, 1'b0, r_run_count - 7'd1};
                    cmd.tail_len   = brle_pkg::REPEAT_BYTES;
                    mid_count      = 7'd1;
                    cmd.wr_idx     = '0;
                end
            end
        end else if (same) begin
            // literal meets a repeat: last literal byte moves into the new repeat
            cmd.lit_en  = 1'b1;
            cmd.lit_n   = (r_run_count > 7'd1) ? r_run_count - 7'd1 : '0;
            cmd.wr_pair = 1'b1;
            cmd.wr_idx  = '0;
            cmd.wr_lo   = r_prev;
            mid_count   = 7'd2;
            mid_repeat  = 1'b1;
        end

        close       = (mid_count >= RUN_LIMIT) || i_end_of_line;
        n_run_count = mid_count;
        n_repeat    = mid_repeat;
        n_prev      = i_value;

        if (close) begin
            n_run_count = '0;
            if (mid_repeat) begin
                close_rec = {i_value, 1'b0, mid_count - 7'd1};
                if (cmd.tail_len == '0) begin
                    cmd.tail[15:0] = close_rec;
                end else begin
                    cmd.tail[31:16] = close_rec;
                end
                cmd.tail_len = cmd.tail_len + brle_pkg::REPEAT_BYTES;
            end else begin
                cmd.lit_en = 1'b1;
                cmd.lit_n  = mid_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_run_count <= '0;
            r_repeat    <= 1'b0;
        end else if (accept) begin
            r_prev      <= n_prev;
            r_run_count <= n_run_count;
            r_repeat    <= n_repeat;
        end
    end

endmodule

// ----- hdl/brle_fifo.sv -----
// Command queue between classifier and emitter of the byte run-length
// encoder. Depends on brle_pkg.
module brle_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  brle_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output brle_pkg::t_cmd  o_data,
    output logic            o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    brle_pkg::t_cmd    r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/brle_back.sv -----
// Emitter of the byte run-length encoder: owns the literal store, carries
// out queued commands and packs records into output words.
// Depends on brle_pkg.
module brle_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    input  brle_pkg::t_cmd                     i_cmd,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [brle_pkg::WORD_W-1:0]        o_packed_bytes,
    output logic [3:0]                         o_byte_count,
    output logic                               o_last
);

    // literal store: 16 rows of 8 bytes, byte writes, one row read a cycle in B_READ only
    logic [brle_pkg::WORD_W-1:0]  mem [brle_pkg::ROWS];
    logic [brle_pkg::WORD_W-1:0]  r_rd_data;

    brle_pkg::t_back_state        r_state, n_state;
    brle_pkg::t_cmd               r_cmd,   n_cmd;
    logic [brle_pkg::ROW_W-1:0]   r_k,     n_k;
    logic [brle_pkg::BYTE_W-1:0]  r_carry, n_carry;

    logic                         r_o_valid;
    logic [brle_pkg::WORD_W-1:0]  r_o_word;
    logic [3:0]                   r_o_count;
    logic                         r_o_last;

    logic                         out_free;
    logic                         load_out;
    logic                         rd_en;
    logic                         mem_we;
    brle_pkg::t_cmd               wr_cmd;
    logic [brle_pkg::ROW_W-1:0]   wr_row;
    logic [brle_pkg::LANES-1:0]   wr_be;
    logic [brle_pkg::WORD_W-1:0]  wr_data;

    logic [brle_pkg::POS_W-1:0]   lit_end;
    logic [brle_pkg::POS_W-1:0]   total;
    logic [brle_pkg::POS_W-1:0]   base;
    logic [brle_pkg::POS_W-1:0]   remain;
    logic [brle_pkg::POS_W-1:0]   pos;
    logic [brle_pkg::POS_W-1:0]   tail_pos;
    logic [brle_pkg::BYTE_W-1:0]  header;
    logic [brle_pkg::WORD_W-1:0]  store_bytes;
    logic [brle_pkg::WORD_W-1:0]  word;
    logic                         word_last;
    logic [3:0]                   word_count;

    assign out_free       = !r_o_valid || !i_stall;
    assign o_valid        = r_o_valid;
    assign o_packed_bytes = r_o_word;
    assign o_byte_count   = r_o_count;
    assign o_last         = r_o_last;

    // compose result word r_k of the current command
    always_comb begin
        lit_end     = r_cmd.lit_en ? ({1'b0, r_cmd.lit_n} + 8'd1) : '0;
        total       = lit_end + {5'd0, r_cmd.tail_len};
        base        = {1'b0, r_k, 3'b000};
        remain      = total - base;
        word_last   = (remain <= 8'd8);
        word_count  = word_last ? remain[3:0] : 4'd8;
        header      = 8'd0 - {1'b0, r_cmd.lit_n};
        // store byte for lane j sits one lane down: lane 0 takes the previous row's top
        store_bytes = {r_rd_data[55:0], r_carry};
        word        = '0;
        pos         = '0;
        tail_pos    = '0;
        for (int j = 0; j < brle_pkg::LANES; j++) begin
            pos = base + 8'(j);
            if (pos < lit_end) begin
                if (pos == '0) begin
                    word[j*8 +: 8] = header;
                end else begin
                    word[j*8 +: 8] = store_bytes[j*8 +: 8];
                end
            end else begin
                tail_pos = pos - lit_end;
                if (tail_pos < {5'd0, r_cmd.tail_len}) begin
                    word[j*8 +: 8] = r_cmd.tail[{tail_pos[1:0], 3'b000} +: 8];
                end
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_k      = r_k;
        n_carry  = r_carry;
        o_pop    = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        mem_we   = 1'b0;
        case (r_state)
            brle_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_k   = '0;
                    // single-byte writes land before any read of this command
                    mem_we = !i_cmd.wr_pair;
                    if (i_cmd.lit_en || (i_cmd.tail_len != '0)) begin
                        n_state = brle_pkg::B_READ;
                    end
                end
            end
            brle_pkg::B_READ: begin
                rd_en   = 1'b1;
                n_state = brle_pkg::B_EMIT;
            end
            brle_pkg::B_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_carry  = r_rd_data[63:56];
                    if (word_last) begin
                        // pair write waits until the old literal is read out
                        mem_we  = r_cmd.wr_pair;
                        n_state = brle_pkg::B_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = brle_pkg::B_READ;
                    end
                end
            end
            default: begin
                n_state = brle_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        wr_cmd  = (r_state == brle_pkg::B_IDLE) ? i_cmd : r_cmd;
        wr_row  = wr_cmd.wr_idx[6:3];
        wr_be   = wr_cmd.wr_pair ? 8'h03 : (8'h01 << wr_cmd.wr_idx[2:0]);
        wr_data = {{6{wr_cmd.wr_lo}}, (wr_cmd.wr_pair ? wr_cmd.wr_hi : wr_cmd.wr_lo),
                   wr_cmd.wr_lo};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int j = 0; j < brle_pkg::LANES; j++) begin
                if (wr_be[j]) begin
                    mem[wr_row][j*8 +: 8] <= wr_data[j*8 +: 8];
                end
            end
        end
        if (rd_en) begin
            r_rd_data <= mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= brle_pkg::B_IDLE;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_carry <= n_carry;
        if (load_out) begin
            r_o_word  <= word;
            r_o_count <= word_count;
            r_o_last  <= word_last;
        end
    end

endmodule

// ----- hdl/byte_run_length_encoder.sv -----
// Top level of the byte run-length encoder: classifier, command queue and
// emitter. Depends on brle_pkg, brle_front, brle_fifo and brle_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | i_valid / o_stall    | i_value, i_end_of_line
//   output   | o_valid / i_stall    | o_packed_bytes, o_byte_count, o_last
//
// The input takes one transaction a cycle while the command queue has room.
// The emitter pops each command in its idle state, then for each result word
// reads one row of the literal store and composes the word; it pops the next
// command only after the last word. An item gives W result words, W up to 16.
// Reset is synchronous and active low; the literal store needs no clearing.
// Output stall holds the result register and backs up through the queue.
module byte_run_length_encoder #(
    parameter int unsigned MAX_RUN     = 127,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [brle_pkg::BYTE_W-1:0]        i_value,
    input  logic                               i_end_of_line,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [brle_pkg::WORD_W-1:0]        o_packed_bytes,
    output logic [3:0]                         o_byte_count,
    output logic                               o_last
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    brle_pkg::t_cmd  front_cmd;
    brle_pkg::t_cmd  head_cmd;

    brle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_end_of_line (i_end_of_line),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    brle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    brle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_packed_bytes (o_packed_bytes),
        .o_byte_count   (o_byte_count),
        .o_last         (o_last)
    );

endmodule

// ----- verif/tb_byte_run_length_encoder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for byte_run_length_encoder: directed table, then
// random runs, literals and noise, checked against an in-bench run encoder.
// Depends on brle_pkg and the encoder RTL.
module tb_byte_run_length_encoder;

    localparam int RUN_LIMIT    = 127;
    localparam int TOTAL_ITEMS  = 460;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_WORDS    = 16;
    localparam int MAX_REC      = 144;

    typedef logic [brle_pkg::BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic [brle_pkg::WORD_W-1:0] packed_bytes;
        logic [3:0]                  byte_count;
        logic                        last;
    } t_enc_word;

    typedef struct packed {
        logic [brle_pkg::BYTE_W-1:0] value;
        logic                        eol;
        logic                        typed;
        logic [brle_pkg::WORD_W-1:0] word;
        logic [3:0]                  count;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [brle_pkg::BYTE_W-1:0] i_value;
    logic                        i_end_of_line;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [brle_pkg::WORD_W-1:0] o_packed_bytes;
    logic [3:0]                  o_byte_count;
    logic                        o_last;

    // encoder state mirror
    logic [brle_pkg::BYTE_W-1:0] prev_byte;
    int unsigned                 run_len;
    logic                        rep_mode;
    logic [brle_pkg::BYTE_W-1:0] lit_bytes [128];
    logic [brle_pkg::BYTE_W-1:0] record_bytes [$];
    t_enc_word                   step_words [$];
    t_enc_word                   expected_words [$];

    int   fail_count = 0;
    int   items_sent = 0;
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    logic pressure_on = 1'b0;
    logic pressure_done = 1'b0;
    int   hold_left = 0;
    logic [brle_pkg::BYTE_W-1:0] last_sent = '0;

    t_dir_row dir_rows [24] = '{
        '{8'h00, 1'b1, 1'b1, 64'h0000, 4'd2},   // lone byte after reset
        '{8'hFF, 1'b1, 1'b1, 64'hFF00, 4'd2},
        '{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h55, 1'b1, 1'b1, 64'h5503, 4'd2},   // repeat of four
        '{8'h11, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h11, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h22, 1'b0, 1'b0, 64'h0, 4'd0},      // short repeat becomes literal
        '{8'h33, 1'b1, 1'b0, 64'h0, 4'd0},
        '{8'h01, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h02, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h03, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h03, 1'b0, 1'b0, 64'h0, 4'd0},      // literal meets a repeat
        '{8'h03, 1'b1, 1'b0, 64'h0, 4'd0},
        '{8'h44, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h44, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h44, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h45, 1'b1, 1'b0, 64'h0, 4'd0},      // long repeat broken, then cut
        '{8'hA5, 1'b0, 1'b0, 64'h0, 4'd0},      // no end mark: runs carry on
        '{8'h5A, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h80, 1'b0, 1'b0, 64'h0, 4'd0},
        '{8'h7F, 1'b1, 1'b0, 64'h0, 4'd0},
        '{8'h80, 1'b1, 1'b1, 64'h8000, 4'd2}
    };

    byte_run_length_encoder #(
        .MAX_RUN (RUN_LIMIT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_end_of_line  (i_end_of_line),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_packed_bytes (o_packed_bytes),
        .o_byte_count   (o_byte_count),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic void put_record_byte(input logic [brle_pkg::BYTE_W-1:0] b);
        if (record_bytes.size() < MAX_REC) record_bytes.insert(record_bytes.size(), b);
    endfunction

    function automatic void put_literal_record(input int unsigned n);
        put_record_byte(t_byte'(256 - n));
        for (int i = 0; i < n; i++) put_record_byte(lit_bytes[i & 127]);
    endfunction

    // Advance the encoder state by one byte; leave its result words in step_words.
    function automatic void rle_encode_byte(input logic [brle_pkg::BYTE_W-1:0] v,
                                            input logic eol);
        int unsigned nres;
        int unsigned cnt;
        t_enc_word   w;
        record_bytes.delete();
        step_words.delete();
        if (run_len == 0) begin
            run_len = 1;
            rep_mode = 1'b1;
            lit_bytes[0] = v;
        end else if (rep_mode) begin
            if (v == prev_byte) begin
                lit_bytes[run_len & 127] = v;
                run_len++;
            end else if (run_len < brle_pkg::SHORT_REPEAT) begin
                lit_bytes[run_len & 127] = v;
                run_len++;
                rep_mode = 1'b0;
            end else begin
                put_record_byte(t_byte'(run_len - 1));
                put_record_byte(prev_byte);
                run_len = 1;
                lit_bytes[0] = v;
            end
        end else begin
            if (v == prev_byte) begin
                put_literal_record(run_len > 1 ? run_len - 1 : 0);
                lit_bytes[0] = prev_byte;
                lit_bytes[1] = v;
                run_len = 2;
                rep_mode = 1'b1;
            end else begin
                lit_bytes[run_len & 127] = v;
                run_len++;
            end
        end
        if (run_len >= RUN_LIMIT || eol) begin
            if (rep_mode) begin
                put_record_byte(t_byte'(run_len - 1));
                put_record_byte(v);
            end else begin
                put_literal_record(run_len);
            end
            run_len = 0;
        end
        prev_byte = v;

        nres = (record_bytes.size() + 7) / 8;
        if (nres > MAX_WORDS) nres = MAX_WORDS;
        for (int k = 0; k < nres; k++) begin
            cnt = record_bytes.size() - k * 8;
            if (cnt > 8) cnt = 8;
            w.packed_bytes = '0;
            for (int i = 0; i < cnt; i++) w.packed_bytes[8*i +: 8] = record_bytes[k*8 + i];
            w.byte_count = 4'(cnt);
            w.last = (k == nres - 1);
            step_words.insert(step_words.size(), w);
        end
    endfunction

    function automatic void update_phase();
        case (items_sent * 5 / TOTAL_ITEMS)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 60; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 60; end
            3: begin sender_idle_pct = 20; stall_pct = 20; end
            default: begin
                sender_idle_pct = 0;
                stall_pct = 0;
                pressure_on = 1'b1;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [brle_pkg::BYTE_W-1:0] v, input logic eol,
                             input logic typed, input logic [brle_pkg::WORD_W-1:0] word,
                             input logic [3:0] cnt);
        t_enc_word w;
        i_valid <= 1'b1;
        i_value <= v;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (o_stall);
        rle_encode_byte(v, eol);
        if (typed) begin
            w.packed_bytes = word;
            w.byte_count = cnt;
            w.last = 1'b1;
            expected_words.insert(expected_words.size(), w);
        end else begin
            foreach (step_words[j])
                expected_words.insert(expected_words.size(), step_words[j]);
        end
        last_sent = v;
        items_sent++;
        update_phase();
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Receiver: random stall, plus one long hold once pressure starts.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (pressure_on && !pressure_done) begin
            i_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            pressure_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_enc_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected transaction: packed_bytes %h byte_count %0d last %0b",
                       o_packed_bytes, o_byte_count, o_last);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_packed_bytes !== exp_w.packed_bytes) begin
                    $error("packed_bytes: expected %h, got %h",
                           exp_w.packed_bytes, o_packed_bytes);
                    fail_count++;
                end
                if (o_byte_count !== exp_w.byte_count) begin
                    $error("byte_count: expected %0d, got %0d", exp_w.byte_count, o_byte_count);
                    fail_count++;
                end
                if (o_last !== exp_w.last) begin
                    $error("last: expected %0b, got %0b", exp_w.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int          seg;
        int          len;
        logic        end_mark;
        logic [brle_pkg::BYTE_W-1:0] v;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        i_end_of_line <= 1'b0;
        prev_byte = '0;
        run_len = 0;
        rep_mode = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_byte(dir_rows[r].value, dir_rows[r].eol, dir_rows[r].typed,
                      dir_rows[r].word, dir_rows[r].count);

        // repeat that hits the limit on its end-of-line byte: one close only
        v = t_byte'($urandom);
        for (int i = 0; i < RUN_LIMIT; i++) send_byte(v, i == RUN_LIMIT - 1, 1'b0, '0, '0);
        // literal past the limit, so it splits into a full record and a new run
        for (int i = 0; i < RUN_LIMIT + 1; i++)
            send_byte(last_sent + t_byte'($urandom_range(1, 255)), 1'b0, 1'b0, '0, '0);

        while (items_sent < TOTAL_ITEMS) begin
            seg = $urandom_range(9);
            end_mark = $urandom_range(1);
            case (seg)
                0, 1, 2, 3: begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(120, 130)
                                                    : $urandom_range(1, 6);
                    v = t_byte'($urandom);
                    for (int i = 0; i < len; i++)
                        send_byte(v, end_mark && i == len - 1, 1'b0, '0, '0);
                end
                4, 5, 6, 7: begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                        send_byte(last_sent + t_byte'($urandom_range(1, 255)),
                                  end_mark && i == len - 1, 1'b0, '0, '0);
                end
                default: begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        v = $urandom_range(1) ? last_sent : t_byte'($urandom);
                        send_byte(v, $urandom_range(3) == 0, 1'b0, '0, '0);
                    end
                end
            endcase
        end
        i_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_byte_run_length_encoder OK");
        else
            $display("tb_byte_run_length_encoder NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_byte_run_length_encoder NOT OK");
        $finish;
    end

endmodule
